### src/stce_pkg.sv
// Shared constants and the exponent coefficient function of the scaled tanh block.
package stce_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int EXP_CELLS  = 16;
    localparam int A_WIDTH    = 16;

    localparam logic [0:0] CFG_SLOPE = 1'b0;
    localparam logic [0:0] CFG_BIAS  = 1'b1;

    // Coefficient exp(-2^(k-11)) in Q0.32, each one the rounded square of the one before.
    function automatic logic [31:0] exp_coef(input int k);
        logic [63:0] c;
        c = 64'd4292870656;
        for (int i = 0; i < k; i++) begin
            c = (c * c + 64'h0000_0000_8000_0000) >> 32;
        end
        return c[31:0];
    endfunction

endpackage

### src/scaled_tanh_activation_with_gradients.sv
// Top level of the scaled tanh activation with its three gradients.
//
//  channel   direction  signals
//  command   in         start, busy, i_sample
//  result    out        o_valid, o_activation, o_grad_sample, o_grad_slope, o_grad_bias
//  config    in         i_cfg_we, i_cfg_idx, i_cfg_data
//
// A sample is taken every cycle and busy stays low.
// Each result follows its sample through the sixteen exponent cells and the DATA_WIDTH - 1
// divider cells of the pipeline.
// Reset clears the valid chain and loads slope 1.0 and bias 0.
// The receiver cannot stall, so nothing is ever held back.
module scaled_tanh_activation_with_gradients #(
    parameter int DATA_WIDTH = stce_pkg::DATA_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [DATA_WIDTH-1:0] i_sample,
    output logic                        o_valid,
    output logic signed [DATA_WIDTH-1:0] o_activation,
    output logic signed [DATA_WIDTH-1:0] o_grad_sample,
    output logic signed [DATA_WIDTH-1:0] o_grad_slope,
    output logic [DATA_WIDTH-2:0]       o_grad_bias,
    input  logic                        i_cfg_we,
    input  logic [0:0]                  i_cfg_idx,
    input  logic [DATA_WIDTH-1:0]       i_cfg_data
);

    localparam int W   = DATA_WIDTH;
    localparam int XF  = W - 4;
    localparam int YF  = W - 2;
    localparam int SH  = 2 * W - 20;
    localparam int ZW  = 2 * W + 1;
    localparam int MW  = 2 * W - 4;
    localparam int RW  = W + 32;
    localparam int AW  = stce_pkg::A_WIDTH;
    localparam int NE  = stce_pkg::EXP_CELLS;
    localparam int ND  = YF + 1;

    logic signed [W-1:0] r_slope;
    logic signed [W-1:0] r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slope <= W'(1) << XF;
            r_bias  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stce_pkg::CFG_SLOPE: r_slope <= i_cfg_data;
                stce_pkg::CFG_BIAS:  r_bias  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Front end: product, offset, saturation and rounding of the argument.
    logic                  r_v1, r_v2, r_v3;
    logic signed [2*W-1:0] r_prod;
    logic signed [ZW-1:0]  r_z;
    logic signed [W-1:0]   r_x1, r_x2, r_x3;
    logic [AW-1:0]         r_a;
    logic                  r_neg3;

    logic signed [ZW-1:0] n_z;
    logic signed [ZW-1:0] lim;
    logic [MW-1:0]        mag;
    logic [MW:0]          rnd;

    always_comb begin
        n_z = $signed({r_prod[2*W-1], r_prod})
            + ($signed({{(W+1){r_bias[W-1]}}, r_bias}) <<< XF);
        lim = ZW'(1) << (2 * W - 5);
        if (r_z > lim || r_z < -lim) begin
            mag = MW'(lim);
        end else if (r_z < 0) begin
            mag = MW'(-r_z);
        end else begin
            mag = MW'(r_z);
        end
        rnd = {1'b0, mag} + ((MW+1)'(1) << (SH - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        r_prod <= r_slope * i_sample;
        r_x1   <= i_sample;
        r_z    <= n_z;
        r_x2   <= r_x1;
        r_a    <= rnd[SH+AW-1:SH];
        r_neg3 <= r_z < 0;
        r_x3   <= r_x2;
    end

    // Exponent chain.
    logic          e_vld [0:NE];
    logic [AW-1:0] e_a   [0:NE];
    logic [32:0]   e_p   [0:NE];
    logic          e_neg [0:NE];
    logic [W-1:0]  e_x   [0:NE];

    assign e_vld[0] = r_v3;
    assign e_a[0]   = r_a;
    assign e_p[0]   = 33'h1_0000_0000;
    assign e_neg[0] = r_neg3;
    assign e_x[0]   = r_x3;

    for (genvar k = 0; k < NE; k++) begin : g_exp
        stce_exp_cell #(.K(k), .W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (e_vld[k]),
            .i_a     (e_a[k]),
            .i_p     (e_p[k]),
            .i_neg   (e_neg[k]),
            .i_x     (e_x[k]),
            .o_vld   (e_vld[k+1]),
            .o_a     (e_a[k+1]),
            .o_p     (e_p[k+1]),
            .o_neg   (e_neg[k+1]),
            .o_x     (e_x[k+1])
        );
    end

    // Dividend and divisor for the ratio.
    logic          r_vp;
    logic [33:0]   r_den;
    logic [RW-1:0] r_num;
    logic          r_negp;
    logic [W-1:0]  r_xp;
    logic [33:0]   n_den;
    logic [RW-1:0] n_num;

    always_comb begin
        n_den = 34'h1_0000_0000 + 34'(e_p[NE]);
        n_num = (RW'(33'h1_0000_0000 - e_p[NE]) << YF) + RW'(n_den >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
        end else begin
            r_vp <= e_vld[NE];
        end
        r_den  <= n_den;
        r_num  <= n_num;
        r_negp <= e_neg[NE];
        r_xp   <= e_x[NE];
    end

    // Divider chain, most significant quotient bit first.
    logic          d_vld [0:ND];
    logic [33:0]   d_den [0:ND];
    logic [RW-1:0] d_rem [0:ND];
    logic [YF:0]   d_q   [0:ND];
    logic          d_neg [0:ND];
    logic [W-1:0]  d_x   [0:ND];

    assign d_vld[0] = r_vp;
    assign d_den[0] = r_den;
    assign d_rem[0] = r_num;
    assign d_q[0]   = '0;
    assign d_neg[0] = r_negp;
    assign d_x[0]   = r_xp;

    for (genvar j = 0; j < ND; j++) begin : g_div
        stce_div_cell #(.BIT(YF - j), .W(W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (d_vld[j]),
            .i_den   (d_den[j]),
            .i_rem   (d_rem[j]),
            .i_q     (d_q[j]),
            .i_neg   (d_neg[j]),
            .i_x     (d_x[j]),
            .o_vld   (d_vld[j+1]),
            .o_den   (d_den[j+1]),
            .o_rem   (d_rem[j+1]),
            .o_q     (d_q[j+1]),
            .o_neg   (d_neg[j+1]),
            .o_x     (d_x[j+1])
        );
    end

    // Back end: sign, square, gradient factor, products, rounding and saturation.
    logic                  r_vy, r_vs, r_vg, r_vm;
    logic signed [W-1:0]   r_y, r_y2, r_y3, r_y4;
    logic signed [W-1:0]   r_xy, r_xs, r_xg;
    logic [2*W-1:0]        r_yy;
    logic [YF:0]           r_g, r_g4;
    logic signed [2*W-1:0] r_ps, r_px;

    logic [2*W-1:0]        sq;
    logic [2*W-1:0]        sq_rnd;
    logic signed [2*W:0]   rs, rx;
    logic signed [W-1:0]   n_gs, n_gx;
    logic signed [2*W:0]   hi_lim, lo_lim;

    always_comb begin
        sq     = (2*W)'(r_y) * (2*W)'(r_y);
        sq_rnd = r_yy + ((2*W)'(1) << (YF - 1));
        hi_lim = (2*W+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
        lo_lim = -hi_lim - (2*W+1)'(1);
        rs = ($signed({r_ps[2*W-1], r_ps}) + $signed((2*W+1)'(1) << (YF - 1))) >>> YF;
        rx = ($signed({r_px[2*W-1], r_px}) + $signed((2*W+1)'(1) << (YF - 1))) >>> YF;
        if (rs > hi_lim) begin
            n_gs = hi_lim[W-1:0];
        end else if (rs < lo_lim) begin
            n_gs = lo_lim[W-1:0];
        end else begin
            n_gs = rs[W-1:0];
        end
        if (rx > hi_lim) begin
            n_gx = hi_lim[W-1:0];
        end else if (rx < lo_lim) begin
            n_gx = lo_lim[W-1:0];
        end else begin
            n_gx = rx[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vy    <= 1'b0;
            r_vs    <= 1'b0;
            r_vg    <= 1'b0;
            r_vm    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vy    <= d_vld[ND];
            r_vs    <= r_vy;
            r_vg    <= r_vs;
            r_vm    <= r_vg;
            o_valid <= r_vm;
        end
        r_y  <= d_neg[ND] ? -W'(d_q[ND]) : W'(d_q[ND]);
        r_xy <= d_x[ND];
        r_y2 <= r_y;
        r_yy <= sq;
        r_xs <= r_xy;
        r_y3 <= r_y2;
        r_g  <= ((YF+1)'(1) << YF) - (YF+1)'(sq_rnd >> YF);
        r_xg <= r_xs;
        r_y4 <= r_y3;
        r_ps <= $signed({1'b0, r_g}) * r_slope;
        r_px <= $signed({1'b0, r_g}) * r_xg;
        r_g4 <= r_g;
        o_activation  <= r_y4;
        o_grad_sample <= n_gs;
        o_grad_slope  <= n_gx;
        o_grad_bias   <= r_g4;
    end

endmodule

### src/stce_exp_cell.sv
// One cell of the exponent chain: multiplies by its coefficient when its bit of the argument is set.
module stce_exp_cell #(
    parameter int K = 0,
    parameter int W = stce_pkg::DATA_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_vld,
    input  logic [stce_pkg::A_WIDTH-1:0]    i_a,
    input  logic [32:0]                     i_p,
    input  logic                            i_neg,
    input  logic [W-1:0]                    i_x,
    output logic                            o_vld,
    output logic [stce_pkg::A_WIDTH-1:0]    o_a,
    output logic [32:0]                     o_p,
    output logic                            o_neg,
    output logic [W-1:0]                    o_x
);

    localparam logic [31:0] COEF = stce_pkg::exp_coef(K);

    logic [65:0] prod;
    logic [32:0] n_p;

    always_comb begin
        prod = 66'(i_p) * 66'(COEF) + 66'h0_0000_0000_8000_0000;
        n_p  = i_a[K] ? prod[64:32] : i_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_a   <= i_a;
        o_p   <= n_p;
        o_neg <= i_neg;
        o_x   <= i_x;
    end

endmodule

### src/stce_div_cell.sv
// One cell of the restoring divider: settles one quotient bit against the shifted divisor.
module stce_div_cell #(
    parameter int BIT = 0,
    parameter int W   = stce_pkg::DATA_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  logic [33:0]     i_den,
    input  logic [W+31:0]   i_rem,
    input  logic [W-2:0]    i_q,
    input  logic            i_neg,
    input  logic [W-1:0]    i_x,
    output logic            o_vld,
    output logic [33:0]     o_den,
    output logic [W+31:0]   o_rem,
    output logic [W-2:0]    o_q,
    output logic            o_neg,
    output logic [W-1:0]    o_x
);

    localparam int RW = W + 32;

    logic [RW-1:0] shifted;
    logic          fits;

    always_comb begin
        shifted = RW'(i_den) << BIT;
        fits    = (i_rem >= shifted);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
        o_den  <= i_den;
        o_rem  <= fits ? (i_rem - shifted) : i_rem;
        o_q    <= i_q | ((W-1)'(fits) << BIT);
        o_neg  <= i_neg;
        o_x    <= i_x;
    end

endmodule

### test/tanh_grad_checker.sv
// Checker that predicts and compares every result of the scaled tanh block.
module tanh_grad_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [15:0] i_sample,
    input  logic        i_valid,
    input  logic [15:0] i_activation,
    input  logic [15:0] i_grad_sample,
    input  logic [15:0] i_grad_slope,
    input  logic [14:0] i_grad_bias,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] act;
        logic [15:0] gs;
        logic [15:0] gx;
        logic [14:0] g;
    } t_tanh_result;

    t_tanh_result pending_results[$];
    logic signed [15:0] gain;
    logic signed [15:0] offset;

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint round14(input longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic t_tanh_result predict_tanh(input logic signed [15:0] x);
        longint z, y, g, gs, gx;
        logic [127:0] p, c;
        logic [63:0] mag, a, num, den, t;
        t_tanh_result r;
        z = longint'(gain) * longint'(x) + longint'(offset) * 4096;
        if (z > (64'sd8 << 24)) z = 64'sd8 << 24;
        if (z < -(64'sd8 << 24)) z = -(64'sd8 << 24);
        mag = (z < 0) ? -z : z;
        a = (mag + 2048) >> 12;
        p = 128'd1 << 32;
        c = 128'd4292870656;
        for (int k = 0; k < 16; k++) begin
            if (a[k]) p = (p * c + (128'd1 << 31)) >> 32;
            c = (c * c + (128'd1 << 31)) >> 32;
        end
        num = ((64'd1 << 32) - p[63:0]) << 14;
        den = (64'd1 << 32) + p[63:0];
        t = (num + den / 2) / den;
        y = (z < 0) ? -longint'(t) : longint'(t);
        g = 16384 - ((y * y + 8192) >>> 14);
        gs = sat16(round14(g * longint'(gain)));
        gx = sat16(round14(g * longint'(x)));
        r.act = y[15:0];
        r.gs = gs[15:0];
        r.gx = gx[15:0];
        r.g = g[14:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (o_errors < 40)
            $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_tanh_result want;
        if (!i_rst_n) begin
            gain <= 16'sd4096;
            offset <= 16'sd0;
            pending_results.delete();
        end else begin
            if (i_valid) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", i_activation, 16'h0);
                end else begin
                    want = pending_results.pop_front();
                    if (i_activation !== want.act)
                        report_mismatch("activation", i_activation, want.act);
                    if (i_grad_sample !== want.gs)
                        report_mismatch("grad_sample", i_grad_sample, want.gs);
                    if (i_grad_slope !== want.gx)
                        report_mismatch("grad_slope", i_grad_slope, want.gx);
                    if (i_grad_bias !== want.g)
                        report_mismatch("grad_bias", {1'b0, i_grad_bias}, {1'b0, want.g});
                end
            end
            if (i_start && !i_busy)
                pending_results.push_back(predict_tanh(i_sample));
            if (i_cfg_we) begin
                if (i_cfg_idx == stce_pkg::CFG_SLOPE) gain <= i_cfg_data;
                else offset <= i_cfg_data;
            end
        end
        o_pending = pending_results.size();
    end
endmodule

### test/tb_scaled_tanh_activation_with_gradients.sv
// Top of the testbench: clock, reset, stimulus and verdict for the scaled tanh block.
module tb_scaled_tanh_activation_with_gradients;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] i_sample = '0;
    logic        o_valid;
    logic [15:0] o_activation, o_grad_sample, o_grad_slope;
    logic [14:0] o_grad_bias;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_idx = stce_pkg::CFG_SLOPE;
    logic [15:0] i_cfg_data = '0;
    int          errors, pending, quiet_cycles;
    logic [15:0] gains[8], offsets[8];
    logic [15:0] directed[16];

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    scaled_tanh_activation_with_gradients dut (.*);

    tanh_grad_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_sample,
        .i_valid(o_valid), .i_activation(o_activation), .i_grad_sample(o_grad_sample),
        .i_grad_slope(o_grad_slope), .i_grad_bias(o_grad_bias),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= 2000) begin
            $display("scaled_tanh_activation_with_gradients: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [15:0] x, input bit may_idle);
        while (may_idle && $urandom_range(99) < 15) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_sample <= x;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_sample();
        case ($urandom_range(2))
            0: return 16'($urandom_range(65535));
            1: return 16'($signed($urandom_range(32768)) - 16384);
            default: return 16'($signed($urandom_range(512)) - 256);
        endcase
    endfunction

    initial begin
        quiet_cycles = 0;
        directed = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h1000, 16'hf000,
                     16'h8000, 16'h7fff, 16'h0800, 16'hf800, 16'h5555, 16'haaaa, 16'h0000,
                     16'h2000, 16'he000};
        gains = '{16'd4096, 16'h7fff, 16'h8000, 16'd0, 16'd1, 16'hf000, 16'd0, 16'd0};
        offsets = '{16'd0, 16'h8000, 16'h7fff, 16'h7fff, 16'd0, 16'd2048, 16'd0, 16'd0};
        gains[6] = 16'($urandom_range(65535));
        offsets[6] = 16'($urandom_range(65535));
        gains[7] = 16'($signed($urandom_range(16384)) - 8192);
        offsets[7] = 16'($signed($urandom_range(4096)) - 2048);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed beats at reset settings: zero, extremes, saturation region.
        foreach (directed[i])
            send_beat(directed[i], 1'b0);
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_reg(stce_pkg::CFG_SLOPE, gains[ph]);
            write_reg(stce_pkg::CFG_BIAS, offsets[ph]);
            send_beat(16'h0000, 1'b0);
            send_beat(16'h7fff, 1'b0);
            send_beat(16'h8000, 1'b0);
            for (int n = 0; n < 200; n++)
                send_beat(random_sample(), ph != 2);
        end
        drain();
        if (errors == 0) begin
            $display("scaled_tanh_activation_with_gradients: match");
        end else begin
            $display("scaled_tanh_activation_with_gradients: mismatch");
        end
        $finish;
    end
endmodule

### sim.f
src/stce_pkg.sv
src/stce_exp_cell.sv
src/stce_div_cell.sv
src/scaled_tanh_activation_with_gradients.sv
test/tanh_grad_checker.sv
test/tb_scaled_tanh_activation_with_gradients.sv
